FILE: hdl/assert_macros.svh
// Assertion helpers shared by the graph detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("wfg assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wfg assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/wfg_pkg.sv
`timescale 1ns / 1ps
package wfg_pkg;

  localparam int MAX_NODES_DEF = 16;

  localparam int OPCODE_W = 2;
  localparam int NODE_W   = 4;
  localparam int COUNT_W  = 5;

  localparam logic [OPCODE_W-1:0] OP_ADD_EDGE   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD_VERTEX = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = 2'd2;

  // config port
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_INIT_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0]   INIT_COUNT_RST = 5'd16;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_KEEP,
    CMD_EDGE,
    CMD_CLEAR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic               accepted;
    logic [COUNT_W-1:0] node_count;
    logic [NODE_W-1:0]  from_node;
    logic [NODE_W-1:0]  to_node;
  } wfg_cmd_t;

endpackage

FILE: hdl/wfg_req_if.sv
`timescale 1ns / 1ps
interface wfg_req_if;
  logic                          valid;
  logic                          ready;
  logic [wfg_pkg::OPCODE_W-1:0]  opcode;
  logic [wfg_pkg::NODE_W-1:0]    from_node;
  logic [wfg_pkg::NODE_W-1:0]    to_node;

  modport source (output valid, output opcode, output from_node, output to_node,
                  input ready);
  modport sink (input valid, input opcode, input from_node, input to_node,
                output ready);
endinterface

FILE: hdl/wfg_rsp_if.sv
`timescale 1ns / 1ps
interface wfg_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic                        cycle_present;
  logic [wfg_pkg::COUNT_W-1:0] node_count;

  modport source (output valid, output accepted, output cycle_present,
                  output node_count, input ready);
  modport sink (input valid, input accepted, input cycle_present,
                input node_count, output ready);
endinterface

FILE: hdl/wfg_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wfg_front #(
  parameter int MAX_NODES = wfg_pkg::MAX_NODES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [wfg_pkg::COUNT_W-1:0] init_count_i,
  wfg_req_if.sink                     req_i,
  output wfg_pkg::wfg_cmd_t           cmd_o,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i
);

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CNT_W > wfg_pkg::COUNT_W) ? CNT_W : wfg_pkg::COUNT_W;

  logic [CNT_W-1:0] live_q, live_d;
  logic             fire;
  logic             ok;
  wfg_pkg::cmd_kind_e kind;

  // saturate a count to the node capacity
  function automatic logic [CNT_W-1:0] clamp_count(input logic [wfg_pkg::COUNT_W-1:0] n);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(n);
    if (ext > CMP_W'(MAX_NODES)) begin
      return CNT_W'(MAX_NODES);
    end
    return CNT_W'(ext);
  endfunction

  assign fire        = req_i.valid && req_i.ready;
  assign req_i.ready = cmd_ready_i;
  assign cmd_valid_o = req_i.valid;

  always_comb begin
    live_d = live_q;
    ok     = 1'b0;
    kind   = wfg_pkg::CMD_KEEP;
    unique case (req_i.opcode)
      wfg_pkg::OP_ADD_EDGE: begin
        ok = (CMP_W'(req_i.from_node) < CMP_W'(live_q)) &&
             (CMP_W'(req_i.to_node) < CMP_W'(live_q));
        kind = ok ? wfg_pkg::CMD_EDGE : wfg_pkg::CMD_KEEP;
      end
      wfg_pkg::OP_ADD_VERTEX: begin
        // the new node never carries edges, so only the count moves
        ok = live_q < CNT_W'(MAX_NODES);
        if (ok) begin
          live_d = live_q + 1'b1;
        end
      end
      wfg_pkg::OP_CLEAR: begin
        ok     = 1'b1;
        kind   = wfg_pkg::CMD_CLEAR;
        live_d = clamp_count(init_count_i);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign cmd_o.kind       = kind;
  assign cmd_o.accepted   = ok;
  assign cmd_o.node_count = wfg_pkg::COUNT_W'(live_d);
  assign cmd_o.from_node  = req_i.from_node;
  assign cmd_o.to_node    = req_i.to_node;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= clamp_count(wfg_pkg::INIT_COUNT_RST);
    end else if (fire) begin
      live_q <= live_d;
    end
  end

  `ASSERT_IMPLIES(a_live_moves_on_request, clk_i, rst_ni, !$stable(live_q), $past(fire))

endmodule

FILE: hdl/wfg_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wfg_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wfg_pkg::wfg_cmd_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wfg_pkg::wfg_cmd_t out_data_o
);

  localparam int DEPTH = wfg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  wfg_pkg::wfg_cmd_t slots_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CW-1:0]     cnt_q;
  logic              push, pop;

  assign in_ready_o  = cnt_q != CW'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = slots_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_HOLDS(a_queue_fill_tracks, clk_i, rst_ni, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))

endmodule

FILE: hdl/wfg_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wfg_back #(
  parameter int MAX_NODES = wfg_pkg::MAX_NODES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wfg_pkg::wfg_cmd_t cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  wfg_rsp_if.source         rsp_o
);

  localparam int IDX_W = $clog2(MAX_NODES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0] st_q, st_d;

  logic [MAX_NODES-1:0] rows_q [MAX_NODES];
  logic [MAX_NODES-1:0] reach_q, reach_d, done_q, done_d;
  logic [MAX_NODES-1:0] pend, pick, sel_row;
  logic                 cycle_q, cycle_d;
  logic [IDX_W-1:0]     src_q, src_d;
  logic [IDX_W-1:0]     src_idx, dst_idx;
  logic [wfg_pkg::COUNT_W-1:0] hold_cnt_q, hold_cnt_d;

  logic out_valid_q, out_acc_q, out_cyc_q;
  logic [wfg_pkg::COUNT_W-1:0] out_cnt_q;
  logic out_free, pop, load, set_edge, clr_all;
  logic ld_acc, ld_cyc;
  logic [wfg_pkg::COUNT_W-1:0] ld_cnt;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign cmd_ready_o = (st_q == ST_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign src_idx     = IDX_W'(cmd_i.from_node);
  assign dst_idx     = IDX_W'(cmd_i.to_node);

  // lowest pending node of the reach set and its row
  always_comb begin
    pend    = reach_q & ~done_q;
    pick    = pend & (~pend + MAX_NODES'(1));
    sel_row = '0;
    for (int j = 0; j < MAX_NODES; j++) begin
      sel_row = sel_row | (rows_q[j] & {MAX_NODES{pick[j]}});
    end
  end

  always_comb begin
    st_d       = st_q;
    reach_d    = reach_q;
    done_d     = done_q;
    cycle_d    = cycle_q;
    src_d      = src_q;
    hold_cnt_d = hold_cnt_q;
    load       = 1'b0;
    ld_acc     = 1'b0;
    ld_cyc     = cycle_q;
    ld_cnt     = hold_cnt_q;
    set_edge   = 1'b0;
    clr_all    = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (pop) begin
          ld_acc = cmd_i.accepted;
          ld_cnt = cmd_i.node_count;
          case (cmd_i.kind)
            wfg_pkg::CMD_CLEAR: begin
              clr_all = 1'b1;
              cycle_d = 1'b0;
              ld_cyc  = 1'b0;
              load    = 1'b1;
            end
            wfg_pkg::CMD_EDGE: begin
              set_edge = 1'b1;
              if (cycle_q || (src_idx == dst_idx)) begin
                cycle_d = 1'b1;
                ld_cyc  = 1'b1;
                load    = 1'b1;
              end else begin
                // new cycle exactly when the destination already reaches the source
                st_d       = ST_SEARCH;
                reach_d    = MAX_NODES'(1) << dst_idx;
                done_d     = '0;
                src_d      = src_idx;
                hold_cnt_d = cmd_i.node_count;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (pend == '0) begin
          st_d = ST_EMIT;
        end else begin
          reach_d = reach_q | sel_row;
          done_d  = done_q | pick;
          if (sel_row[src_q]) begin
            cycle_d = 1'b1;
            st_d    = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load   = 1'b1;
          ld_acc = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_NODES; r++) begin
        rows_q[r] <= '0;
      end
    end else if (clr_all) begin
      for (int r = 0; r < MAX_NODES; r++) begin
        rows_q[r] <= '0;
      end
    end else if (set_edge) begin
      rows_q[src_idx][dst_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cycle_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      cycle_q <= cycle_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    reach_q    <= reach_d;
    done_q     <= done_d;
    src_q      <= src_d;
    hold_cnt_q <= hold_cnt_d;
    if (load) begin
      out_acc_q <= ld_acc;
      out_cyc_q <= ld_cyc;
      out_cnt_q <= ld_cnt;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.accepted      = out_acc_q;
  assign rsp_o.cycle_present = out_cyc_q;
  assign rsp_o.node_count    = out_cnt_q;

  `ASSERT_IMPLIES(a_cycle_drops_on_clear, clk_i, rst_ni, $fell(cycle_q), $past(pop) && ($past(cmd_i.kind) == wfg_pkg::CMD_CLEAR))
  `ASSERT_HOLDS(a_search_progress, clk_i, rst_ni, (st_q == ST_SEARCH) |=> ((st_q == ST_EMIT) || ($countones(done_q) == $countones($past(done_q)) + 1)))

endmodule

FILE: hdl/wait_for_graph_cycle_detector_unit.sv
// Results: clear, add vertex, rejected requests, self loops and edges on an already
//   cyclic graph load the registered result straight from the idle state; any other
//   new edge first walks the nodes reached from its destination, then loads the
//   result from the emit state.
// Throughput: one request per cycle into a 2-entry queue while it has room; the back end runs one
//   request at a time, paced by the one-row-per-cycle reachability walk.
// Reset: asynchronous, active low; empty graph, no cycle, count = min(16, MAX_NODES).
`timescale 1ns / 1ps
module wait_for_graph_cycle_detector_unit #(
  parameter int MAX_NODES = wfg_pkg::MAX_NODES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  wfg_req_if.sink                          req_i,
  wfg_rsp_if.source                        rsp_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wfg_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wfg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [wfg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  // Configuration: one register, initial_node_count, at byte address 0.
  logic [wfg_pkg::COUNT_W-1:0] init_cnt_q;
  logic                        reg_hit;
  logic                        cfg_wr;

  // Front end to queue, queue to back end.
  wfg_pkg::wfg_cmd_t front_cmd, back_cmd;
  logic              front_valid, front_ready;
  logic              back_valid, back_ready;

  assign pready  = 1'b1;
  assign reg_hit = paddr[wfg_pkg::CFG_ADDR_W-1:2] == wfg_pkg::REG_INIT_COUNT;
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;

  // Read back the stored count, zero for addresses past the register list.
  assign prdata = reg_hit ? wfg_pkg::APB_DATA_W'(init_cnt_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= wfg_pkg::INIT_COUNT_RST;
    end else if (cfg_wr) begin
      init_cnt_q <= pwdata[wfg_pkg::COUNT_W-1:0];
    end
  end

  // Front end: validate the request against the live count, advance that count,
  // and hand the back end a command that says what to do with the matrix.
  wfg_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_count_i (init_cnt_q),
    .req_i        (req_i),
    .cmd_o        (front_cmd),
    .cmd_valid_o  (front_valid),
    .cmd_ready_i  (front_ready)
  );

  // Short queue so the front keeps taking requests while a search runs.
  wfg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_data_i   (front_cmd),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_data_o  (back_cmd)
  );

  // Back end: own the adjacency matrix and the sticky cycle flag; on a new edge that
  // is no self loop and meets no cycle yet, walk reachability from its destination
  // one row per cycle, then drive the registered result.
  wfg_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

  // Graph size as built by default; the predictor mirrors it.
  localparam int MAX_NODES = wfg_pkg::MAX_NODES_DEF;

  // Opcode value that the block must leave alone.
  localparam logic [wfg_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // Register index past the end of the map; writes to it must be dropped.
  localparam int UNMAPPED_IDX = 1;

  // Settle time, chosen beyond the worst response latency.
  localparam int SETTLE_CYCLES = MAX_NODES + 8;

  // Give up after this many cycles without any request or result moving.
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 225;

  typedef struct {
    logic [wfg_pkg::OPCODE_W-1:0] opcode;
    logic [wfg_pkg::NODE_W-1:0]   from_node;
    logic [wfg_pkg::NODE_W-1:0]   to_node;
  } graph_request_t;

  typedef struct packed {
    logic                        accepted;
    logic                        cycle_present;
    logic [wfg_pkg::COUNT_W-1:0] node_count;
  } graph_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [wfg_pkg::CFG_ADDR_W-1:0] paddr;
  logic [wfg_pkg::APB_DATA_W-1:0] pwdata;
  logic [wfg_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  wfg_req_if req_if ();
  wfg_rsp_if rsp_if ();

  wait_for_graph_cycle_detector_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block: adjacency rows, live count and the count register.
  logic [MAX_NODES-1:0]        edge_rows [MAX_NODES];
  logic [wfg_pkg::COUNT_W-1:0] live_count;
  logic [wfg_pkg::COUNT_W-1:0] init_count_cfg;

  graph_request_t pending_requests [$];
  graph_result_t  expected_results [$];
  graph_request_t next_request;

  int  requests_queued;
  int  requests_taken;
  int  error_count;
  int  quiet_cycles;
  int  send_gap;
  int  stall_left;
  bit  calm;

  // Count the live nodes the stimulus expects, so edges can be aimed in range.
  int  gen_count;

  // Peel off live nodes that have no edge into the remaining set; whatever
  // survives sits on a directed cycle or leads into one.
  function automatic logic graph_has_cycle();
    logic [MAX_NODES-1:0] remain;
    logic                 changed;
    for (int i = 0; i < MAX_NODES; i++)
      remain[i] = (i < live_count);
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int i = 0; i < MAX_NODES; i++) begin
        if (remain[i] && (edge_rows[i] & remain) == '0) begin
          remain[i] = 1'b0;
          changed   = 1'b1;
        end
      end
    end
    return |remain;
  endfunction

  // Apply one request to the shadow graph and return the result it must produce.
  function automatic graph_result_t apply_request(graph_request_t req);
    graph_result_t res;
    int            n;
    res.accepted = 1'b0;
    case (req.opcode)
      wfg_pkg::OP_ADD_EDGE: begin
        if (req.from_node < live_count && req.to_node < live_count) begin
          edge_rows[req.from_node][req.to_node] = 1'b1;
          res.accepted = 1'b1;
        end
      end
      wfg_pkg::OP_ADD_VERTEX: begin
        if (live_count < MAX_NODES) begin
          // Wipe the new node's row and column before it goes live.
          n = live_count;
          edge_rows[n] = '0;
          for (int i = 0; i < MAX_NODES; i++)
            edge_rows[i][n] = 1'b0;
          live_count   = live_count + 1'b1;
          res.accepted = 1'b1;
        end
      end
      wfg_pkg::OP_CLEAR: begin
        for (int i = 0; i < MAX_NODES; i++)
          edge_rows[i] = '0;
        live_count   = (init_count_cfg > MAX_NODES) ?
                       wfg_pkg::COUNT_W'(MAX_NODES) : init_count_cfg;
        res.accepted = 1'b1;
      end
      default: ;
    endcase
    res.cycle_present = graph_has_cycle();
    res.node_count    = live_count;
    return res;
  endfunction

  // Queue one request for the driver and track the count it leaves behind.
  task automatic queue_request(logic [wfg_pkg::OPCODE_W-1:0] op, int src, int dst);
    graph_request_t req;
    req.opcode    = op;
    req.from_node = wfg_pkg::NODE_W'(src);
    req.to_node   = wfg_pkg::NODE_W'(dst);
    pending_requests.push_back(req);
    requests_queued++;
    if (op == wfg_pkg::OP_CLEAR)
      gen_count = (init_count_cfg > MAX_NODES) ? MAX_NODES : init_count_cfg;
    else if (op == wfg_pkg::OP_ADD_VERTEX && gen_count < MAX_NODES)
      gen_count++;
  endtask

  // Hold until every queued request went in and every result came back,
  // then let the back end run dry before touching the register.
  task automatic settle();
    while (requests_taken != requests_queued || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic is_write, input int idx,
                            input logic [wfg_pkg::APB_DATA_W-1:0] wdata,
                            output logic [wfg_pkg::APB_DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= wfg_pkg::CFG_ADDR_W'(idx * 4);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the count register, mirror it, and read it back.
  task automatic load_node_count(int value);
    logic [wfg_pkg::APB_DATA_W-1:0] rdata;
    apb_access(1'b1, wfg_pkg::REG_INIT_COUNT, wfg_pkg::APB_DATA_W'(value), rdata);
    init_count_cfg = wfg_pkg::COUNT_W'(value);
    apb_access(1'b0, wfg_pkg::REG_INIT_COUNT, '0, rdata);
    if (rdata !== wfg_pkg::APB_DATA_W'(init_count_cfg)) begin
      $error("initial_node_count readback: expected %0d, actual %0d",
             init_count_cfg, rdata);
      error_count++;
    end
  endtask

  // Request driver: drain the pending queue, with random idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.opcode    <= wfg_pkg::OP_ADD_EDGE;
      req_if.from_node <= '0;
      req_if.to_node   <= '0;
      send_gap = 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (send_gap == 0 && !calm && $urandom_range(0, 11) == 0)
        send_gap = $urandom_range(1, 9);
      if (send_gap > 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        next_request = pending_requests.pop_front();
        req_if.valid     <= 1'b1;
        req_if.opcode    <= next_request.opcode;
        req_if.from_node <= next_request.from_node;
        req_if.to_node   <= next_request.to_node;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result sink: stall in random bursts, except in the last phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 9);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: check each result against the oldest expectation, then
  // predict the result of any request taken at this edge.
  always @(posedge clk_i) begin
    graph_result_t  want;
    graph_request_t seen;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.accepted !== want.accepted) begin
            $error("accepted: expected %0d, actual %0d", want.accepted, rsp_if.accepted);
            error_count++;
          end
          if (rsp_if.cycle_present !== want.cycle_present) begin
            $error("cycle_present: expected %0d, actual %0d",
                   want.cycle_present, rsp_if.cycle_present);
            error_count++;
          end
          if (rsp_if.node_count !== want.node_count) begin
            $error("node_count: expected %0d, actual %0d",
                   want.node_count, rsp_if.node_count);
            error_count++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        seen.opcode    = req_if.opcode;
        seen.from_node = req_if.from_node;
        seen.to_node   = req_if.to_node;
        expected_results.push_back(apply_request(seen));
        requests_taken++;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL wait_for_graph_cycle_detector_unit");
        $finish;
      end
    end
  end

  initial begin
    logic [wfg_pkg::APB_DATA_W-1:0] rdata;
    int roll;
    int a;
    int b;
    int pick;

    // Drive every input to a known value and hold reset.
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_if.valid     = 1'b0;
    req_if.opcode    = wfg_pkg::OP_ADD_EDGE;
    req_if.from_node = '0;
    req_if.to_node   = '0;
    rsp_if.ready     = 1'b0;
    calm            = 1'b0;
    error_count     = 0;
    quiet_cycles    = 0;
    requests_queued = 0;
    requests_taken  = 0;
    for (int i = 0; i < MAX_NODES; i++)
      edge_rows[i] = '0;
    init_count_cfg = wfg_pkg::INIT_COUNT_RST;
    live_count     = (wfg_pkg::INIT_COUNT_RST > MAX_NODES) ?
                     wfg_pkg::COUNT_W'(MAX_NODES) : wfg_pkg::INIT_COUNT_RST;
    gen_count      = live_count;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset count, full graph: simple edge, two-node loop, self loop on the
    // top node, add vertex when full, unused opcode, repeated edge.
    queue_request(wfg_pkg::OP_ADD_EDGE, 0, 1);
    queue_request(wfg_pkg::OP_ADD_EDGE, 1, 0);
    queue_request(wfg_pkg::OP_CLEAR, 0, 0);
    queue_request(wfg_pkg::OP_ADD_EDGE, 15, 15);
    queue_request(wfg_pkg::OP_ADD_VERTEX, 0, 0);
    queue_request(OP_UNUSED, 15, 15);
    queue_request(wfg_pkg::OP_CLEAR, 15, 15);
    queue_request(wfg_pkg::OP_ADD_EDGE, 15, 0);
    queue_request(wfg_pkg::OP_ADD_EDGE, 0, 15);
    queue_request(wfg_pkg::OP_ADD_EDGE, 0, 15);
    settle();

    // Two live nodes: edges touching a dead node bounce, then grow by one.
    load_node_count(2);
    queue_request(wfg_pkg::OP_CLEAR, 0, 0);
    queue_request(wfg_pkg::OP_ADD_EDGE, 2, 0);
    queue_request(wfg_pkg::OP_ADD_EDGE, 0, 2);
    queue_request(wfg_pkg::OP_ADD_EDGE, 1, 1);
    queue_request(wfg_pkg::OP_ADD_VERTEX, 0, 0);
    queue_request(wfg_pkg::OP_ADD_EDGE, 2, 1);
    settle();

    // Empty graph after clear.
    load_node_count(0);
    queue_request(wfg_pkg::OP_CLEAR, 0, 0);
    queue_request(wfg_pkg::OP_ADD_EDGE, 0, 0);
    queue_request(wfg_pkg::OP_ADD_VERTEX, 0, 0);
    queue_request(wfg_pkg::OP_ADD_VERTEX, 0, 0);
    queue_request(wfg_pkg::OP_ADD_EDGE, 1, 0);
    settle();

    // Drop a write past the register map, then saturate the count.
    apb_access(1'b1, UNMAPPED_IDX, wfg_pkg::APB_DATA_W'(7), rdata);
    load_node_count(31);
    queue_request(wfg_pkg::OP_CLEAR, 0, 0);
    settle();

    // Random phases: mostly forward edges in range, which keep the graph
    // acyclic until a back edge lands, plus vertex growth, clears and noise.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1)
        calm = 1'b1;
      pick = $urandom_range(0, 3);
      case (pick)
        0:       load_node_count($urandom_range(0, 4));
        1:       load_node_count($urandom_range(5, MAX_NODES));
        2:       load_node_count(MAX_NODES);
        default: load_node_count($urandom_range(0, 31));
      endcase
      queue_request(wfg_pkg::OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15));
      for (int k = 1; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          queue_request(wfg_pkg::OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15));
        end else if (roll < 7) begin
          queue_request(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15));
        end else if (roll < 19) begin
          queue_request(wfg_pkg::OP_ADD_VERTEX, $urandom_range(0, 15),
                        $urandom_range(0, 15));
        end else if (gen_count > 0 && roll < 90) begin
          a = $urandom_range(0, gen_count - 1);
          b = $urandom_range(0, gen_count - 1);
          if (roll < 80 && a > b)
            queue_request(wfg_pkg::OP_ADD_EDGE, b, a);
          else
            queue_request(wfg_pkg::OP_ADD_EDGE, a, b);
        end else begin
          queue_request(wfg_pkg::OP_ADD_EDGE, $urandom_range(0, 15),
                        $urandom_range(0, 15));
        end
      end
      settle();
    end

    if (error_count == 0)
      $display("PASS wait_for_graph_cycle_detector_unit");
    else
      $display("FAIL wait_for_graph_cycle_detector_unit");
    $finish;
  end

endmodule
